@@ sv/ufsr_pkg.sv @@
// shared widths, command and register codes, and the configuration bundle
package ufsr_pkg;

   // fixed field widths
   localparam int NODE_W = 10;
   localparam int CNT_W  = 11;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // command codes carried on req_cmd
   typedef enum logic {
      CMD_INIT  = 1'b0,
      CMD_UNION = 1'b1
   } cmd_type;

   // register index taken from the word address
   typedef enum logic {
      REG_CITY_COUNT    = 1'b0,
      REG_STATION_COUNT = 1'b1
   } reg_index_type;

   // configuration handed from the register block to the sequencer
   typedef struct packed {
      logic [NODE_W-1:0] city_count;
      logic [NODE_W-1:0] station_count;
   } cfg_type;

endpackage

@@ sv/ufsr_csr.sv @@
// configuration registers behind the apb-style port
module ufsr_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ufsr_pkg::ADDR_W-1:0]  paddr,
   input  logic [ufsr_pkg::DATA_W-1:0]  pwdata,
   output logic [ufsr_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output ufsr_pkg::cfg_type            cfg
);
   import ufsr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_hit;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_hit  = psel & penable & pwrite & pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_sel)
            REG_CITY_COUNT:    cfg_in.city_count    = pwdata[NODE_W-1:0];
            REG_STATION_COUNT: cfg_in.station_count = pwdata[NODE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read-back mux
   always_comb begin
      case (reg_sel)
         REG_CITY_COUNT:    prdata = DATA_W'(cfg_ff.city_count);
         REG_STATION_COUNT: prdata = DATA_W'(cfg_ff.station_count);
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/ufsr_table.sv @@
// node table memory: one write port, one read port with registered data
module ufsr_table #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 22
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] entry_mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // read port, data registered for use in the cycle after the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ufsr_seq.sv @@
// sequencer: table sweep, root walks with path compression and linking
module ufsr_seq #(
   parameter  int NODE_SLOTS = 1024,
   localparam int IDX_W      = $clog2(NODE_SLOTS),
   localparam int ENT_W      = IDX_W + ufsr_pkg::CNT_W + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [ufsr_pkg::NODE_W-1:0] req_node_a,
   input  logic [ufsr_pkg::NODE_W-1:0] req_node_b,
   output logic                        rsp_valid,
   output logic [ufsr_pkg::NODE_W-1:0] rsp_safe_total,
   output logic                        rsp_joined,
   input  ufsr_pkg::cfg_type           cfg,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_addr,
   input  logic [ENT_W-1:0]            rd_data,
   output logic                        wr_en,
   output logic [IDX_W-1:0]            wr_addr,
   output logic [ENT_W-1:0]            wr_data
);
   import ufsr_pkg::*;

   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WALK_A,
      ST_COMP_A,
      ST_WALK_B,
      ST_COMP_B,
      ST_LINK_A
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic [NODE_W-1:0]  sw_city_ff, sw_city_in;
   logic [CNT_W-1:0]   sw_last_ff, sw_last_in;
   logic               sw_reply_ff, sw_reply_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_joined_ff, rsp_joined_in;

   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   node_a_ff, node_a_in;
   logic [IDX_W-1:0]   node_b_ff, node_b_in;
   logic [IDX_W-1:0]   root_a_ff, root_a_in;
   logic [IDX_W-1:0]   root_b_ff, root_b_in;
   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]   cnt_b_ff, cnt_b_in;
   logic               flg_a_ff, flg_a_in;
   logic               flg_b_ff, flg_b_in;

   logic [IDX_W-1:0]   rd_par;
   logic [CNT_W-1:0]   rd_cnt;
   logic               rd_flg;
   logic               a_ok, b_ok;
   logic               is_city, is_station;
   logic [ENT_W-1:0]   sweep_entry;

   // fields of the entry just read
   assign rd_par = rd_data[ENT_W-1 -: IDX_W];
   assign rd_cnt = rd_data[CNT_W:1];
   assign rd_flg = rd_data[0];

   // endpoints beyond the table make the union a no-op
   assign a_ok = (32'(req_node_a) < NODE_SLOTS);
   assign b_ok = (32'(req_node_b) < NODE_SLOTS);

   // entry written by the sweep: cities carry a count, stations a flag
   assign is_city    = (sweep_ff != '0) && (CMP_W'(sweep_ff) <= CMP_W'(sw_city_ff));
   assign is_station = (sweep_ff != '0) && !is_city
                       && (CMP_W'(sweep_ff) <= CMP_W'(sw_last_ff));
   assign sweep_entry = {sweep_ff, CNT_W'(is_city), is_station};

   // next state and memory access
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      sw_city_in    = sw_city_ff;
      sw_last_in    = sw_last_ff;
      sw_reply_in   = sw_reply_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_joined_in = 1'b0;
      cur_in        = cur_ff;
      node_a_in     = node_a_ff;
      node_b_in     = node_b_ff;
      root_a_in     = root_a_ff;
      root_b_in     = root_b_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      flg_a_in      = flg_a_ff;
      flg_b_in      = flg_b_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = sweep_entry;

      case (state_ff)
         // one entry a cycle over the whole table
         ST_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = sweep_entry;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in     = ST_IDLE;
               rsp_valid_in = sw_reply_ff;
            end
         end

         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_INIT) begin
                  state_in    = ST_SWEEP;
                  sweep_in    = '0;
                  sw_city_in  = cfg.city_count;
                  sw_last_in  = CNT_W'(cfg.city_count) + CNT_W'(cfg.station_count);
                  sw_reply_in = 1'b1;
                  total_in    = '0;
               end else if (a_ok && b_ok) begin
                  node_a_in = IDX_W'(req_node_a);
                  node_b_in = IDX_W'(req_node_b);
                  cur_in    = IDX_W'(req_node_a);
                  rd_en     = 1'b1;
                  rd_addr   = IDX_W'(req_node_a);
                  state_in  = ST_WALK_A;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         // follow parents of node a up to its root
         ST_WALK_A: begin
            rd_en = 1'b1;
            if (rd_par == cur_ff) begin
               root_a_in = cur_ff;
               cnt_a_in  = rd_cnt;
               flg_a_in  = rd_flg;
               cur_in    = node_a_ff;
               rd_addr   = node_a_ff;
               state_in  = ST_COMP_A;
            end else begin
               cur_in  = rd_par;
               rd_addr = rd_par;
            end
         end

         // second pass over the path of a, pointing each node at the root
         ST_COMP_A: begin
            rd_en = 1'b1;
            if (cur_ff == root_a_ff) begin
               cur_in   = node_b_ff;
               rd_addr  = node_b_ff;
               state_in = ST_WALK_B;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {root_a_ff, rd_cnt, rd_flg};
               cur_in  = rd_par;
               rd_addr = rd_par;
            end
         end

         ST_WALK_B: begin
            rd_en = 1'b1;
            if (rd_par == cur_ff) begin
               root_b_in = cur_ff;
               cnt_b_in  = rd_cnt;
               flg_b_in  = rd_flg;
               cur_in    = node_b_ff;
               rd_addr   = node_b_ff;
               state_in  = ST_COMP_B;
            end else begin
               cur_in  = rd_par;
               rd_addr = rd_par;
            end
         end

         // compress path of b; at its end hang root b under root a if the roots differ
         ST_COMP_B: begin
            if (cur_ff == root_b_ff) begin
               if (root_a_ff == root_b_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = root_b_ff;
                  wr_data = {root_a_ff, cnt_b_ff, flg_b_ff};
                  if (flg_a_ff && !flg_b_ff) begin
                     total_in = total_ff + cnt_b_ff;
                  end else if (!flg_a_ff && flg_b_ff) begin
                     total_in = total_ff + cnt_a_ff;
                  end
                  state_in = ST_LINK_A;
               end
            end else begin
               rd_en   = 1'b1;
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {root_b_ff, rd_cnt, rd_flg};
               cur_in  = rd_par;
               rd_addr = rd_par;
            end
         end

         // merged count and flag onto the surviving root
         ST_LINK_A: begin
            wr_en         = 1'b1;
            wr_addr       = root_a_ff;
            wr_data       = {root_a_ff, cnt_a_ff + cnt_b_ff, flg_a_ff | flg_b_ff};
            rsp_valid_in  = 1'b1;
            rsp_joined_in = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and registered outputs; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         sw_city_ff    <= '0;
         sw_last_ff    <= '0;
         sw_reply_ff   <= 1'b0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_joined_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         sw_city_ff    <= sw_city_in;
         sw_last_ff    <= sw_last_in;
         sw_reply_ff   <= sw_reply_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_joined_ff <= rsp_joined_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
      root_a_ff <= root_a_in;
      root_b_ff <= root_b_in;
      cnt_a_ff  <= cnt_a_in;
      cnt_b_ff  <= cnt_b_in;
      flg_a_ff  <= flg_a_in;
      flg_b_ff  <= flg_b_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_joined     = rsp_joined_ff;
   assign rsp_safe_total = total_ff[NODE_W-1:0];

   // a result only ever appears once the sequencer is back at rest
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while busy");

   // linking only happens between two distinct roots
   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK_A) |-> (root_a_ff != root_b_ff))
      else $error("link of a root to itself");

   // compression never rewrites the root of the path
   a_comp_not_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP_A && wr_en) |-> (wr_addr != root_a_ff))
      else $error("compression wrote the root entry");

   // no same-entry read and write in one cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write of one entry in a cycle");

   // total moves only while an item is being worked on
   a_total_steady: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !start) |=> $stable(total_ff))
      else $error("total changed while idle");

endmodule

@@ sv/union_find_source_reach_counter.sv @@
// top level: disjoint-set engine counting cities that reach a station
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  request  req_cmd, req_node_a, req_node_b         taken when start & !busy
//  result   rsp_safe_total, rsp_joined              one cycle, rsp_valid strobe
//  config   psel, penable, pwrite, paddr, pwdata,   apb write, pready tied high
//           prdata, pready
//
// an init item sweeps the table one entry a cycle, with its result in the
// cycle after the last entry is written. a union item walks the parent chain
// of endpoint a through the node table to its root, one entry a cycle, then
// compresses that path, and does the same for endpoint b; when two components
// are linked a last step writes the merged count and flag onto root a.
// an endpoint outside the table gives its result on the next cycle.
// after reset a clearing pass over the whole table runs with busy high.
// results cannot be held off; a new item may be taken in the result cycle.
module union_find_source_reach_counter #(
   parameter int NODE_SLOTS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic [ufsr_pkg::NODE_W-1:0]  req_node_a,
   input  logic [ufsr_pkg::NODE_W-1:0]  req_node_b,
   output logic                         rsp_valid,
   output logic [ufsr_pkg::NODE_W-1:0]  rsp_safe_total,
   output logic                         rsp_joined,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ufsr_pkg::ADDR_W-1:0]  paddr,
   input  logic [ufsr_pkg::DATA_W-1:0]  pwdata,
   output logic [ufsr_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import ufsr_pkg::*;

   localparam int IDX_W = $clog2(NODE_SLOTS);
   localparam int ENT_W = IDX_W + CNT_W + 1;

   cfg_type          cfg;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [ENT_W-1:0] rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;

   // configuration registers
   ufsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // node table: parent, member count, source flag
   ufsr_table #(
      .DEPTH (NODE_SLOTS),
      .AW    (IDX_W),
      .DW    (ENT_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // command sequencer
   ufsr_seq #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .rsp_valid      (rsp_valid),
      .rsp_safe_total (rsp_safe_total),
      .rsp_joined     (rsp_joined),
      .cfg            (cfg),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the source reach counter, driven by plain tasks
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ufsr_pkg::*;

   localparam int SLOTS        = 1024;
   localparam int MAX_GAP      = 17;
   localparam int STALL_LIMIT  = 6000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 950;
   localparam int MAX_REPORTS  = 10;

   // one expected result, tagged with the number of the item that causes it
   typedef struct {
      logic [NODE_W-1:0] safe_total;
      logic              joined;
      int unsigned       item_no;
   } reach_result_type;

   // forest predictor plus the queue of results still to arrive
   class reach_scoreboard_type;
      logic [NODE_W-1:0] parent      [SLOTS];
      logic [CNT_W-1:0]  members     [SLOTS];
      logic              has_station [SLOTS];
      logic [CNT_W-1:0]  safe_sum;
      logic [NODE_W-1:0] cities;
      logic [NODE_W-1:0] stations;
      reach_result_type  awaited_q[$];
      int unsigned       items_seen;
      int unsigned       mismatches;

      function new();
         cities     = '0;
         stations   = '0;
         items_seen = 0;
         mismatches = 0;
         clear_forest();
      endfunction

      function void clear_forest();
         for (int i = 0; i < SLOTS; i++) begin
            parent[i]      = NODE_W'(i);
            members[i]     = '0;
            has_station[i] = 1'b0;
         end
         safe_sum = '0;
      endfunction

      function void set_register(reg_index_type idx, logic [NODE_W-1:0] value);
         case (idx)
            REG_CITY_COUNT:    cities   = value;
            REG_STATION_COUNT: stations = value;
            default: ;
         endcase
      endfunction

      // root lookup, every node on the path is pointed straight at the root
      function logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] x);
         logic [NODE_W-1:0] r;
         logic [NODE_W-1:0] cur;
         logic [NODE_W-1:0] nxt;
         r = x;
         while (parent[r] != r)
            r = parent[r];
         cur = x;
         while (cur != r) begin
            nxt         = parent[cur];
            parent[cur] = r;
            cur         = nxt;
         end
         return r;
      endfunction

      function void log_failure(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%s", what);
      endfunction

      // apply one accepted item to the forest and queue its result
      function void note_command(cmd_type cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
         logic [CNT_W-1:0]  last_node;
         logic [NODE_W-1:0] ra;
         logic [NODE_W-1:0] rb;
         logic              linked;
         reach_result_type  res;
         linked = 1'b0;
         if (cmd == CMD_INIT) begin
            // city range already fits the table; the station range is clipped
            last_node = {1'b0, cities} + {1'b0, stations};
            if (last_node > CNT_W'(SLOTS - 1))
               last_node = CNT_W'(SLOTS - 1);
            clear_forest();
            for (int i = 1; i <= int'(last_node); i++) begin
               if (i <= int'(cities))
                  members[i] = CNT_W'(1);
               else
                  has_station[i] = 1'b1;
            end
         end else if (int'(a) < SLOTS && int'(b) < SLOTS) begin
            ra = find_root(a);
            rb = find_root(b);
            if (ra != rb) begin
               // the side without a station becomes safe
               if (has_station[ra] && !has_station[rb])
                  safe_sum = safe_sum + members[rb];
               else if (!has_station[ra] && has_station[rb])
                  safe_sum = safe_sum + members[ra];
               parent[rb]      = ra;
               members[ra]     = members[ra] + members[rb];
               has_station[ra] = has_station[ra] | has_station[rb];
               linked          = 1'b1;
            end
         end
         res.safe_total = safe_sum[NODE_W-1:0];
         res.joined     = linked;
         res.item_no    = items_seen;
         items_seen++;
         awaited_q.push_back(res);
      endfunction

      function void check_result(logic [NODE_W-1:0] safe_total, logic joined);
         reach_result_type want;
         if (awaited_q.size() == 0) begin
            log_failure($sformatf("unexpected result: safe_total %0d joined %0b",
                                  safe_total, joined));
            return;
         end
         want = awaited_q.pop_front();
         if (safe_total !== want.safe_total || joined !== want.joined)
            log_failure($sformatf(
               "item %0d: safe_total exp %0d got %0d, joined exp %0b got %0b",
               want.item_no, want.safe_total, safe_total, want.joined, joined));
      endfunction

      function int outstanding();
         return awaited_q.size();
      endfunction

      function int total_failures();
         return mismatches + awaited_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_cmd;
   logic [NODE_W-1:0] req_node_a;
   logic [NODE_W-1:0] req_node_b;
   logic              rsp_valid;
   logic [NODE_W-1:0] rsp_safe_total;
   logic              rsp_joined;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   reach_scoreboard_type sb;
   int                   stall_cycles = 0;
   int                   quiet_run;
   int                   random_items;

   union_find_source_reach_counter #(
      .NODE_SLOTS(SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .rsp_valid      (rsp_valid),
      .rsp_safe_total (rsp_safe_total),
      .rsp_joined     (rsp_joined),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result monitor: the block cannot be stalled, every strobe is a result
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result(rsp_safe_total, rsp_joined);
   end

   // watchdog on cycles with no item taken and no result
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // gap before the next item, with occasional back-to-back stretches
   function automatic int pick_gap();
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         quiet_run = $urandom_range(5, 30);
      return $urandom_range(0, MAX_GAP);
   endfunction

   // mostly nodes in use, sometimes anywhere in the table
   function automatic int pick_node(int span);
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(0, span);
      return $urandom_range(0, SLOTS - 1);
   endfunction

   task automatic send_item(cmd_type cmd, int a, int b, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_node_a <= NODE_W'(a);
      req_node_b <= NODE_W'(b);
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_command(cmd, NODE_W'(a), NODE_W'(b));
   endtask

   // wait until every result is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, int value);
      logic [DATA_W-1:0] junk;
      junk = ($urandom_range(0, 1) == 1) ? DATA_W'($urandom) : '0;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= (junk << NODE_W) | DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.set_register(idx, NODE_W'(value));
   endtask

   task automatic csr_read_check(reg_index_type idx, int value);
      logic [DATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== DATA_W'(value))
         sb.log_failure($sformatf("register %s: exp %0d got %0h", idx.name(), value, got));
   endtask

   task automatic configure(int city, int station);
      settle();
      csr_write(REG_CITY_COUNT, city);
      csr_write(REG_STATION_COUNT, station);
      csr_read_check(REG_CITY_COUNT, city);
      csr_read_check(REG_STATION_COUNT, station);
   endtask

   // one random phase: new counts, usually a rebuild, then a run of unions
   task automatic run_phase(int city, int station, int n_items, bit with_init);
      int span;
      int roll;
      int a;
      int b;
      span = (city + station + 2 > SLOTS - 1) ? SLOTS - 1 : city + station + 2;
      configure(city, station);
      if (with_init) begin
         send_item(CMD_INIT, $urandom_range(0, SLOTS - 1), $urandom_range(0, SLOTS - 1),
                   pick_gap());
         random_items++;
      end
      for (int k = 0; k < n_items; k++) begin
         roll = $urandom_range(0, 99);
         if (roll == 0) begin
            send_item(CMD_INIT, $urandom_range(0, SLOTS - 1), $urandom_range(0, SLOTS - 1),
                      pick_gap());
         end else begin
            a = pick_node(span);
            b = (roll < 5) ? a : pick_node(span);
            send_item(CMD_UNION, a, b, pick_gap());
         end
         random_items++;
      end
   endtask

   initial begin
      int sel;
      int city;
      int station;
      sb           = new();
      quiet_run    = 0;
      random_items = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_cmd      = CMD_INIT;
      req_node_a   = '0;
      req_node_b   = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // unions on the reset forest, before any rebuild
      send_item(CMD_UNION, 0, SLOTS - 1, pick_gap());
      send_item(CMD_UNION, SLOTS - 1, 0, pick_gap());

      // small forest: cities 1..4, stations 5..6
      configure(4, 2);
      send_item(CMD_INIT, 0, 0, pick_gap());
      send_item(CMD_UNION, 1, 2, pick_gap());
      send_item(CMD_UNION, 2, 1, pick_gap());
      send_item(CMD_UNION, 1, 5, pick_gap());
      send_item(CMD_UNION, 6, 3, pick_gap());
      send_item(CMD_UNION, 5, 6, pick_gap());
      send_item(CMD_UNION, 4, 4, pick_gap());
      send_item(CMD_UNION, 0, 7, pick_gap());
      send_item(CMD_UNION, 7, 4, pick_gap());
      send_item(CMD_UNION, 4, 2, pick_gap());

      // counts at the top, station range clipped away
      configure(SLOTS - 1, SLOTS - 1);
      send_item(CMD_INIT, SLOTS - 1, SLOTS - 1, pick_gap());
      send_item(CMD_UNION, 1, SLOTS - 1, pick_gap());

      // stations clipped at the end of the table
      configure(1000, SLOTS - 1);
      send_item(CMD_INIT, 0, 0, pick_gap());
      send_item(CMD_UNION, SLOTS - 1, 1, pick_gap());
      send_item(CMD_UNION, 1000, 1001, pick_gap());

      // stations only, then an empty forest
      configure(0, SLOTS - 1);
      send_item(CMD_INIT, 0, 0, pick_gap());
      send_item(CMD_UNION, 1, SLOTS - 1, pick_gap());
      configure(0, 0);
      send_item(CMD_INIT, 0, 0, pick_gap());
      send_item(CMD_UNION, 1, 2, pick_gap());

      // random phases over a spread of forest sizes
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            city    = ($urandom_range(0, 1) == 1) ? SLOTS - 1 : 0;
            station = ($urandom_range(0, 1) == 1) ? SLOTS - 1 : 0;
         end else if (sel == 1) begin
            city    = $urandom_range(300, SLOTS - 1);
            station = $urandom_range(1, 40);
         end else begin
            city    = $urandom_range(1, 64);
            station = $urandom_range(0, 10);
         end
         run_phase(city, station, $urandom_range(20, 90), $urandom_range(0, 9) != 0);
      end

      // drain
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.total_failures() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
